@@ rtl/lsap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsap_pkg: shared types, constants and table builder for the auto panner
// Holds register indices, LFO shape codes, the controller-to-datapath command
// struct and the quarter-sine table generator that is evaluated at elaboration.
// ----------------------------------------------------------------------------
package lsap_pkg;

    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 24;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 31;

    localparam logic [CFG_IDX_BITS-1:0] REG_LFO_SHAPE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_OFFSET = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAN_DEPTH    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH_GAIN   = 3'd4;

    localparam logic [1:0]  SHAPE_SINE     = 2'd0;
    localparam logic [1:0]  SHAPE_TRIANGLE = 2'd1;

    localparam logic [15:0] PAN_DEPTH_RST  = 16'd32768;
    localparam logic [15:0] WIDTH_GAIN_RST = 16'd16384;
    localparam logic [15:0] GAIN_FULL      = 16'd32767;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [2:0] {
        MUL_SIDE  = 3'd0,
        MUL_PAN_L = 3'd1,
        MUL_PAN_R = 3'd2,
        MUL_OUT_L = 3'd3,
        MUL_OUT_R = 3'd4
    } t_mul_sel;

    typedef enum logic [1:0] {
        ROM_SINE_L = 2'd0,
        ROM_SINE_R = 2'd1,
        ROM_GAIN_L = 2'd2,
        ROM_GAIN_R = 2'd3
    } t_rom_sel;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_rom_sel rom_sel;
        logic     widen;
        logic     lfo_l;
        logic     lfo_r;
        logic     gain_l;
        logic     gain_r;
        logic     res_l;
        logic     load_out;
    } t_dp_cmd;

    // Entry i of the quarter sine: Q30 series to degree 15, scaled to Q15.
    function automatic logic [15:0] f_sine_entry(input int unsigned i,
                                                 input int unsigned abits);
        longint x;
        longint s;
        longint t;
        x = (HALF_PI_Q30 * longint'(i)) >>> abits;
        s = x;
        t = x;
        for (int k = 1; k <= 7; k++) begin
            t = (t * x) >>> 30;
            t = (t * x) >>> 30;
            case (k)
                1:       t = t / 6;
                2:       t = t / 20;
                3:       t = t / 42;
                4:       t = t / 72;
                5:       t = t / 110;
                6:       t = t / 156;
                default: t = t / 210;
            endcase
            if ((k & 1) == 1) begin
                s = s - t;
            end else begin
                s = s + t;
            end
        end
        if (s < 0) begin
            s = 0;
        end
        s = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (s > 32767) begin
            s = 32767;
        end
        return 16'(s);
    endfunction

endpackage

@@ rtl/lfo_stereo_auto_panner_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_stereo_auto_panner_top: LFO driven equal-power stereo auto panner
//
// Channel  Dir  Handshake              Payload
// s        in   i_s_tvalid/o_s_tready  i_s_tdata: left_in, right_in
// m        out  o_m_tvalid/i_m_tready  o_m_tdata: left_out, right_out
// cfg      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// An item passes through the accept step and eight sequencer steps, set by
// the single shared multiplier (five products) and the registered sine ROM
// port (four reads). Reset is synchronous and restores the register defaults
// and a zero LFO phase; the ROM is constant and needs no clearing. The result
// register lets the next item in while a result waits; if that result is still
// unread when the next one completes, the sequencer holds in its last step.
// ----------------------------------------------------------------------------
module lfo_stereo_auto_panner_top
    import lsap_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int TDATA_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [TDATA_W-1:0]        i_s_tdata,   // left_in, right_in
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [TDATA_W-1:0]        o_m_tdata,   // left_out, right_out
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_dp_cmd                    w_cmd;
    logic signed [SAMPLE_BITS-1:0] w_left_out;
    logic signed [SAMPLE_BITS-1:0] w_right_out;

    assign o_cfg_ready = 1'b1;

    lsap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    lsap_dp #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_left_in   (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_right_in  (i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .o_left_out  (w_left_out),
        .o_right_out (w_right_out)
    );

    assign o_m_tdata = TDATA_W'({w_right_out, w_left_out});

endmodule

@@ rtl/lsap_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsap_ctrl: sequencer for the auto panner
// Walks one item through the shared multiplier and sine ROM, and owns the
// input ready and the output valid.
// ----------------------------------------------------------------------------
module lsap_ctrl
    import lsap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SIDE   = 9'b000000010,
        ST_WIDEN  = 9'b000000100,
        ST_PAN_L  = 9'b000001000,
        ST_PAN_R  = 9'b000010000,
        ST_GAIN_R = 9'b000100000,
        ST_OUT_L  = 9'b001000000,
        ST_OUT_R  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.mul_sel = MUL_SIDE;
        w_cmd.rom_sel = ROM_SINE_L;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = ST_SIDE;
                end
            end
            ST_SIDE: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_SIDE;
                w_cmd.rom_sel = ROM_SINE_L;
                n_state       = ST_WIDEN;
            end
            ST_WIDEN: begin
                w_cmd.widen   = 1'b1;
                w_cmd.lfo_l   = 1'b1;
                w_cmd.rom_sel = ROM_SINE_R;
                n_state       = ST_PAN_L;
            end
            ST_PAN_L: begin
                w_cmd.lfo_r   = 1'b1;
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_PAN_L;
                n_state       = ST_PAN_R;
            end
            ST_PAN_R: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_PAN_R;
                w_cmd.rom_sel = ROM_GAIN_L;
                n_state       = ST_GAIN_R;
            end
            ST_GAIN_R: begin
                w_cmd.gain_l  = 1'b1;
                w_cmd.rom_sel = ROM_GAIN_R;
                n_state       = ST_OUT_L;
            end
            ST_OUT_L: begin
                w_cmd.gain_r  = 1'b1;
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_OUT_L;
                n_state       = ST_OUT_R;
            end
            ST_OUT_R: begin
                w_cmd.res_l   = 1'b1;
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_OUT_R;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                // hold here while the previous item still sits unread
                if (!r_out_valid || i_m_tready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = w_cmd;

endmodule

@@ rtl/lsap_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsap_dp: datapath of the auto panner
// Configuration registers, LFO phase, quarter-sine ROM with registered read,
// one shared signed multiplier, rounding and output saturation.
// ----------------------------------------------------------------------------
module lsap_dp
    import lsap_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_dp_cmd                         i_cmd,
    input  logic                            i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]   i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]   i_right_in,
    output logic signed [SAMPLE_BITS-1:0]   o_left_out,
    output logic signed [SAMPLE_BITS-1:0]   o_right_out
);

    localparam int SB       = SAMPLE_BITS;
    localparam int AB       = TABLE_ADDR_BITS;
    localparam int TBL_N    = 1 << AB;
    localparam int SH       = 16 - AB;
    localparam int DW       = SB + 1;
    localparam int AW       = SB + 3;
    localparam int BW       = 18;
    localparam int PW       = AW + BW;
    localparam int OW       = PW - 15;
    localparam int SUMW     = SB + 18;
    localparam int IDX_HALF = 1 << (SH - 1);

    // configuration and phase
    logic [1:0]  r_lfo_shape;
    logic [30:0] r_phase_step;
    logic [15:0] r_right_offset;
    logic [15:0] r_pan_depth;
    logic [15:0] r_width_gain;
    logic [31:0] r_lfo_phase;
    logic [31:0] r_ph_r;

    // item payload
    logic signed [SB-1:0] r_left_in;
    logic signed [SB-1:0] r_right_in;
    logic signed [PW-1:0] r_prod;
    logic [15:0]          r_rom_q;
    logic signed [15:0]   r_lfo_l;
    logic signed [15:0]   r_lfo_r;
    logic signed [AW-1:0] r_wl;
    logic signed [AW-1:0] r_wr;
    logic [15:0]          r_gain_l;
    logic [15:0]          r_gain_r;
    logic signed [SB-1:0] r_res_l;
    logic signed [SB-1:0] r_left_out;
    logic signed [SB-1:0] r_right_out;

    logic [15:0]          w_rom [TBL_N];
    logic [AB:0]          w_rom_addr;
    logic [AB:0]          w_sine_addr;
    logic [31:0]          w_rom_ph;
    logic [AB-1:0]        w_sine_idx;
    logic signed [PW-1:0] w_prod_adj;
    logic signed [OW-1:0] w_prod_rnd;
    logic signed [16:0]   w_pan;
    logic signed [17:0]   w_gain_v;
    logic [17:0]          w_gain_vr;
    logic [31:0]          w_lfo_ph;
    logic signed [17:0]   w_lfo_raw;
    logic signed [17:0]   w_tri_t;
    logic signed [15:0]   w_lfo;
    logic [15:0]          w_depth;
    logic signed [DW-1:0] w_diff;
    logic signed [DW-1:0] w_sum;
    logic signed [SUMW-1:0] w_midq;
    logic signed [SUMW-1:0] w_sideq;
    logic signed [SUMW-1:0] w_acc_l;
    logic signed [SUMW-1:0] w_acc_r;
    logic signed [AW-1:0] w_mul_a;
    logic signed [BW-1:0] w_mul_b;
    logic signed [PW-1:0] n_prod;
    logic signed [SB-1:0] w_sat;

    for (genvar g = 0; g < TBL_N; g++) begin : g_rom
        assign w_rom[g] = f_sine_entry(g, AB);
    end

    // sine ROM address: falling quadrants read from the top, N reads as full scale
    assign w_rom_ph   = (i_cmd.rom_sel == ROM_SINE_R) ? r_ph_r : r_lfo_phase;
    assign w_sine_idx = w_rom_ph[29 -: AB];
    assign w_sine_addr = w_rom_ph[30] ? ({1'b1, {AB{1'b0}}} - {1'b0, w_sine_idx})
                                      : {1'b0, w_sine_idx};

    // pan from the product held in r_prod, then the gain index
    assign w_prod_adj = r_prod + PW'(16384);
    assign w_prod_rnd = w_prod_adj[PW-1:15];
    assign w_pan      = w_prod_rnd[16:0];
    assign w_gain_v   = (i_cmd.rom_sel == ROM_GAIN_R) ? (18'sd32768 - 18'(w_pan))
                                                      : (18'sd32768 + 18'(w_pan));
    assign w_gain_vr  = 18'(w_gain_v) + 18'(IDX_HALF);

    always_comb begin
        case (i_cmd.rom_sel)
            ROM_SINE_L, ROM_SINE_R: w_rom_addr = w_sine_addr;
            ROM_GAIN_L, ROM_GAIN_R: w_rom_addr = w_gain_vr[16:SH];
            default:                w_rom_addr = w_sine_addr;
        endcase
    end

    // LFO value from the ROM output or straight from the phase
    assign w_lfo_ph = i_cmd.lfo_r ? r_ph_r : r_lfo_phase;
    assign w_tri_t  = {1'b0, w_lfo_ph[31:15]};

    always_comb begin
        case (r_lfo_shape)
            SHAPE_SINE: begin
                w_lfo_raw = w_lfo_ph[31] ? -{2'b00, r_rom_q} : {2'b00, r_rom_q};
            end
            SHAPE_TRIANGLE: begin
                if (w_tri_t < 18'sd32768) begin
                    w_lfo_raw = w_tri_t;
                end else if (w_tri_t < 18'sd98304) begin
                    w_lfo_raw = 18'sd65536 - w_tri_t;
                end else begin
                    w_lfo_raw = w_tri_t - 18'sd131072;
                end
            end
            default: begin
                w_lfo_raw = w_lfo_ph[31] ? -18'sd32767 : 18'sd32767;
            end
        endcase
        if (w_lfo_raw > 18'sd32767) begin
            w_lfo = 16'sd32767;
        end else if (w_lfo_raw < -18'sd32767) begin
            w_lfo = -16'sd32767;
        end else begin
            w_lfo = w_lfo_raw[15:0];
        end
    end

    // mid/side widening, side product taken from r_prod
    assign w_diff  = {r_left_in[SB-1], r_left_in} - {r_right_in[SB-1], r_right_in};
    assign w_sum   = {r_left_in[SB-1], r_left_in} + {r_right_in[SB-1], r_right_in};
    assign w_midq  = SUMW'(w_sum) <<< 14;
    assign w_sideq = r_prod[SUMW-1:0];
    assign w_acc_l = w_midq + w_sideq + SUMW'(16384);
    assign w_acc_r = w_midq - w_sideq + SUMW'(16384);

    // shared multiplier
    assign w_depth = (r_pan_depth > PAN_DEPTH_RST) ? PAN_DEPTH_RST : r_pan_depth;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SIDE: begin
                w_mul_a = AW'(w_diff);
                w_mul_b = {2'b00, r_width_gain};
            end
            MUL_PAN_L: begin
                w_mul_a = AW'(r_lfo_l);
                w_mul_b = {2'b00, w_depth};
            end
            MUL_PAN_R: begin
                w_mul_a = AW'(r_lfo_r);
                w_mul_b = {2'b00, w_depth};
            end
            MUL_OUT_L: begin
                w_mul_a = r_wl;
                w_mul_b = {2'b00, r_gain_l};
            end
            MUL_OUT_R: begin
                w_mul_a = r_wr;
                w_mul_b = {2'b00, r_gain_r};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign n_prod = w_mul_a * w_mul_b;

    // clamp the rounded product to the sample range
    always_comb begin
        if ((&w_prod_rnd[OW-1:SB-1]) || !(|w_prod_rnd[OW-1:SB-1])) begin
            w_sat = w_prod_rnd[SB-1:0];
        end else if (w_prod_rnd[OW-1]) begin
            w_sat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(SB-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfo_shape    <= SHAPE_SINE;
            r_phase_step   <= '0;
            r_right_offset <= '0;
            r_pan_depth    <= PAN_DEPTH_RST;
            r_width_gain   <= WIDTH_GAIN_RST;
            r_lfo_phase    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LFO_SHAPE:    r_lfo_shape    <= i_cfg_data[1:0];
                    REG_PHASE_STEP:   r_phase_step   <= i_cfg_data[30:0];
                    REG_RIGHT_OFFSET: r_right_offset <= i_cfg_data[15:0];
                    REG_PAN_DEPTH:    r_pan_depth    <= i_cfg_data[15:0];
                    REG_WIDTH_GAIN:   r_width_gain   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_out) begin
                r_lfo_phase <= r_lfo_phase + {1'b0, r_phase_step};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= w_rom_addr[AB] ? GAIN_FULL : w_rom[w_rom_addr[AB-1:0]];
        if (i_cmd.load_in) begin
            r_left_in  <= i_left_in;
            r_right_in <= i_right_in;
            r_ph_r     <= r_lfo_phase + {r_right_offset, 16'h0000};
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.widen) begin
            r_wl <= w_acc_l[SUMW-1:15];
            r_wr <= w_acc_r[SUMW-1:15];
        end
        if (i_cmd.lfo_l) begin
            r_lfo_l <= w_lfo;
        end
        if (i_cmd.lfo_r) begin
            r_lfo_r <= w_lfo;
        end
        if (i_cmd.gain_l) begin
            r_gain_l <= r_rom_q;
        end
        if (i_cmd.gain_r) begin
            r_gain_r <= r_rom_q;
        end
        if (i_cmd.res_l) begin
            r_res_l <= w_sat;
        end
        if (i_cmd.load_out) begin
            r_left_out  <= r_res_l;
            r_right_out <= w_sat;
        end
    end

    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

@@ tb/tb_lfo_stereo_auto_panner_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfo_stereo_auto_panner_top: self-checking bench for the stereo auto panner
// Drives stereo pairs into the slave stream and register writes into the
// config channel. A bit-exact panner model predicts each output pair, and a
// monitor compares every accepted result with the oldest prediction. Both
// stream sides idle at random, apart from one stretch of steady flow.
// ----------------------------------------------------------------------------
module tb_lfo_stereo_auto_panner_top
    import lsap_pkg::*;
();

    localparam int ABITS       = TABLE_ADDR_BITS_DEF;
    localparam int NTAB        = 1 << ABITS;
    localparam int SBITS       = SAMPLE_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [1:0] SHAPE_SQUARE     = 2'd2;
    localparam logic [1:0] SHAPE_SQUARE_ALT = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [SBITS-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SBITS-1:0] SMP_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [SBITS-1:0] right_smp;
        logic signed [SBITS-1:0] left_smp;
    } t_pan_pair;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_tvalid;
    logic                     o_s_tready;
    logic [2*SBITS-1:0]       s_tdata;     // left_in, right_in
    logic                     o_m_tvalid;
    logic                     m_tready;
    logic [2*SBITS-1:0]       o_m_tdata;   // left_out, right_out
    logic                     cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // Shadow of the block's registers and LFO phase
    logic [1:0]  cur_shape;
    logic [30:0] cur_step;
    logic [15:0] cur_offset;
    logic [15:0] cur_depth;
    logic [15:0] cur_width;
    logic [31:0] lfo_phase;
    int          sine_rom [NTAB];

    t_pan_pair   pan_expect_q [$];
    t_pan_pair   want;
    int          error_count;
    int          cycle_count;
    bit          steady_flow;

    lfo_stereo_auto_panner_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Panner model
    // ------------------------------------------------------------------
    function automatic int quarter_sine_entry(input int unsigned i);
        longint x;
        longint acc;
        longint term;
        int     k;
        x = (HALF_PI_Q30 * longint'(i)) >>> ABITS;
        acc = x;
        term = x;
        for (k = 1; k <= 7; k++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
        return (acc > 32767) ? 32767 : int'(acc);
    endfunction

    function automatic int lfo_level(input logic [31:0] ph);
        int               mag;
        int               lvl;
        int               tri_pos;
        logic [ABITS-1:0] idx;
        case (cur_shape)
            SHAPE_SINE: begin
                idx = ph[29 -: ABITS];
                // falling quadrants read the mirrored entry, top of the quarter at 1.0
                if (ph[30]) begin
                    mag = (idx == 0) ? 32767 : sine_rom[NTAB - int'(idx)];
                end else begin
                    mag = sine_rom[idx];
                end
                lvl = ph[31] ? -mag : mag;
            end
            SHAPE_TRIANGLE: begin
                tri_pos = ph[31:15];
                if (tri_pos < 32768) begin
                    lvl = tri_pos;
                end else if (tri_pos < 98304) begin
                    lvl = 65536 - tri_pos;
                end else begin
                    lvl = tri_pos - 131072;
                end
            end
            default: begin
                lvl = ph[31] ? -32767 : 32767;
            end
        endcase
        if (lvl > 32767) begin
            lvl = 32767;
        end
        if (lvl < -32767) begin
            lvl = -32767;
        end
        return lvl;
    endfunction

    function automatic int pan_amount(input int lvl);
        int     d;
        longint prod;
        d = (cur_depth > 16'd32768) ? 32768 : int'(cur_depth);
        prod = longint'(lvl) * longint'(d);
        return int'((prod + 16384) >>> 15);
    endfunction

    function automatic int gain_lookup(input int v);
        int idx;
        idx = (v + (1 << (15 - ABITS))) >>> (16 - ABITS);
        return (idx >= NTAB) ? 32767 : sine_rom[idx];
    endfunction

    function automatic logic signed [SBITS-1:0] scale_sat(input longint w, input int g);
        longint o;
        longint hi;
        hi = (64'sd1 <<< (SBITS - 1)) - 1;
        o = (w * longint'(g) + 16384) >>> 15;
        if (o > hi) begin
            o = hi;
        end
        if (o < -hi - 1) begin
            o = -hi - 1;
        end
        return o[SBITS-1:0];
    endfunction

    // Widen, pan and gain one stereo pair, then advance the LFO phase.
    function automatic t_pan_pair pan_pair_predict(input logic signed [SBITS-1:0] l_smp,
                                                   input logic signed [SBITS-1:0] r_smp);
        t_pan_pair   res;
        longint      l;
        longint      r;
        longint      midq;
        longint      sideq;
        logic [31:0] ph_right;
        int          gain_l;
        int          gain_r;
        l = l_smp;
        r = r_smp;
        ph_right = lfo_phase + {cur_offset, 16'h0000};
        gain_l = gain_lookup(32768 + pan_amount(lfo_level(lfo_phase)));
        gain_r = gain_lookup(32768 - pan_amount(lfo_level(ph_right)));
        midq = 16384 * (l + r);
        sideq = longint'(cur_width) * (l - r);
        res.left_smp = scale_sat((midq + sideq + 16384) >>> 15, gain_l);
        res.right_smp = scale_sat((midq - sideq + 16384) >>> 15, gain_r);
        lfo_phase = lfo_phase + {1'b0, cur_step};
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stream and register drivers
    // ------------------------------------------------------------------
    task automatic send_pair(input logic signed [SBITS-1:0] l_smp,
                             input logic signed [SBITS-1:0] r_smp);
        if (!steady_flow && $urandom_range(99) < 37) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {r_smp, l_smp};
        do @(posedge i_clk); while (!o_s_tready);
        pan_expect_q.push_back(pan_pair_predict(l_smp, r_smp));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pan_expect_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_LFO_SHAPE:    cur_shape = val[1:0];
            REG_PHASE_STEP:   cur_step = val[30:0];
            REG_RIGHT_OFFSET: cur_offset = val[15:0];
            REG_PAN_DEPTH:    cur_depth = val[15:0];
            REG_WIDTH_GAIN:   cur_width = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [SBITS-1:0] random_sample();
        case ($urandom_range(9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return SBITS'($signed($urandom_range(0, 1023)) - 512);
            default: return SBITS'($urandom());
        endcase
    endfunction

    task automatic randomise_settings();
        write_reg(REG_LFO_SHAPE, CFG_DATA_BITS'($urandom_range(3)));
        case ($urandom_range(3))
            0:       write_reg(REG_PHASE_STEP, CFG_DATA_BITS'($urandom_range(0, 4095)));
            1:       write_reg(REG_PHASE_STEP, 31'h7FFF_FFFF);
            default: write_reg(REG_PHASE_STEP, CFG_DATA_BITS'($urandom()));
        endcase
        write_reg(REG_RIGHT_OFFSET, CFG_DATA_BITS'($urandom_range(0, 65535)));
        case ($urandom_range(3))
            0:       write_reg(REG_PAN_DEPTH, 31'd32768);
            1:       write_reg(REG_PAN_DEPTH, CFG_DATA_BITS'($urandom_range(32769, 65535)));
            default: write_reg(REG_PAN_DEPTH, CFG_DATA_BITS'($urandom_range(0, 32768)));
        endcase
        if ($urandom_range(3) == 0) begin
            write_reg(REG_WIDTH_GAIN, 31'd16384);
        end else begin
            write_reg(REG_WIDTH_GAIN, CFG_DATA_BITS'($urandom_range(0, 65535)));
        end
    endtask

    // ------------------------------------------------------------------
    // Result monitor and timeout
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        m_tready = steady_flow ? 1'b1 : ($urandom_range(99) >= 37);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pan_expect_q.size() == 0) begin
                $error("unexpected result: tdata %h", o_m_tdata);
                error_count++;
            end else begin
                want = pan_expect_q.pop_front();
                if (o_m_tdata[SBITS-1:0] !== want.left_smp) begin
                    $error("left_out: expected %0d, got %0d", want.left_smp,
                           $signed(o_m_tdata[SBITS-1:0]));
                    error_count++;
                end
                if (o_m_tdata[2*SBITS-1:SBITS] !== want.right_smp) begin
                    $error("right_out: expected %0d, got %0d", want.right_smp,
                           $signed(o_m_tdata[2*SBITS-1:SBITS]));
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        send_pair(SMP_MAX, SMP_MAX);
        send_pair(SMP_MIN, SMP_MIN);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(SMP_MIN, SMP_MAX);
        send_pair(24'sd0, 24'sd0);
        send_pair(24'sd1, -24'sd1);
    endtask

    // Full width pushes the widened sample past the output range; zero width keeps only the mid part.
    task automatic test_width_extremes();
        wait_drained();
        write_reg(REG_WIDTH_GAIN, 31'd65535);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(SMP_MIN, SMP_MAX);
        wait_drained();
        write_reg(REG_WIDTH_GAIN, 31'd0);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(24'sh555555, 24'shAAAAAA);
    endtask

    // Quarter-cycle steps land on the quadrant edges and the triangle clamps.
    task automatic test_lfo_shapes();
        logic [1:0] shapes [4];
        shapes = '{SHAPE_SINE, SHAPE_TRIANGLE, SHAPE_SQUARE, SHAPE_SQUARE_ALT};
        wait_drained();
        write_reg(REG_WIDTH_GAIN, 31'd16384);
        write_reg(REG_PHASE_STEP, 31'h4000_0000);
        write_reg(REG_RIGHT_OFFSET, 31'h4000);
        write_reg(REG_PAN_DEPTH, 31'd65535);
        foreach (shapes[s]) begin
            wait_drained();
            write_reg(REG_LFO_SHAPE, CFG_DATA_BITS'(shapes[s]));
            repeat (4) send_pair(random_sample(), random_sample());
        end
        // phase wrap on both channels
        wait_drained();
        write_reg(REG_PHASE_STEP, 31'h7FFF_FFFF);
        write_reg(REG_RIGHT_OFFSET, 31'hFFFF);
        repeat (2) send_pair(random_sample(), random_sample());
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            case (p)
                0: begin
                    write_reg(REG_LFO_SHAPE, CFG_DATA_BITS'(SHAPE_SINE));
                    write_reg(REG_PHASE_STEP, 31'd1);
                    write_reg(REG_PAN_DEPTH, 31'd0);
                    write_reg(REG_WIDTH_GAIN, 31'd0);
                end
                1: begin
                    write_reg(REG_LFO_SHAPE, CFG_DATA_BITS'(SHAPE_TRIANGLE));
                    write_reg(REG_PHASE_STEP, 31'h7FFF_FFFF);
                    write_reg(REG_RIGHT_OFFSET, 31'd0);
                    write_reg(REG_PAN_DEPTH, 31'd32768);
                    write_reg(REG_WIDTH_GAIN, 31'd65535);
                end
                default: begin
                    randomise_settings();
                end
            endcase
            // unmapped index must leave every register alone
            if (p == 4) begin
                write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom()));
            end
            for (int n = 0; n < 150; n++) begin
                // hold off until every pending result has come back
                if (p == 3 && n == 75) begin
                    wait_drained();
                end
                send_pair(random_sample(), random_sample());
            end
        end
    endtask

    task automatic test_steady_flow();
        wait_drained();
        randomise_settings();
        steady_flow = 1'b1;
        repeat (200) send_pair(random_sample(), random_sample());
        wait_drained();
        steady_flow = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < NTAB; i++) begin
            sine_rom[i] = quarter_sine_entry(i);
        end
        cur_shape = SHAPE_SINE;
        cur_step = '0;
        cur_offset = '0;
        cur_depth = PAN_DEPTH_RST;
        cur_width = WIDTH_GAIN_RST;
        lfo_phase = '0;
        error_count = 0;
        cycle_count = 0;
        steady_flow = 1'b0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_width_extremes();
        test_lfo_shapes();
        test_random_settings();
        test_steady_flow();

        wait_drained();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
